>>> design/lsep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsep_pkg
// Shared types and codes for the LSB stego stream extractor.
// ----------------------------------------------------------------------------
package lsep_pkg;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] image_byte;
        logic       start_of_file;
    } t_in_item;

    // Output transfer payload
    typedef struct packed {
        logic [2:0]  section;
        logic [31:0] field_value;
        logic        last_payload;
        logic [1:0]  error_code;
    } t_out_item;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  header_bytes;
        logic [15:0] magic_word;
        logic        check_magic;
    } t_cfg;

    // Parse phases
    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_MAGIC    = 3'd1,
        PH_EXT_LEN  = 3'd2,
        PH_EXT_DATA = 3'd3,
        PH_PAY_LEN  = 3'd4,
        PH_PAY_DATA = 3'd5,
        PH_STOP     = 3'd6
    } t_phase;

    // Section tags
    localparam logic [2:0] SEC_MAGIC    = 3'd0;
    localparam logic [2:0] SEC_EXT_LEN  = 3'd1;
    localparam logic [2:0] SEC_EXT_BYTE = 3'd2;
    localparam logic [2:0] SEC_PAY_LEN  = 3'd3;
    localparam logic [2:0] SEC_PAY_BYTE = 3'd4;
    localparam logic [2:0] SEC_ERROR    = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_MAGIC    = 2'd1;
    localparam logic [1:0] ERR_EXT_ZERO = 2'd2;
    localparam logic [1:0] ERR_PAY_ZERO = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER_BYTES = 2'd0;
    localparam logic [1:0] CFG_MAGIC_WORD   = 2'd1;
    localparam logic [1:0] CFG_CHECK_MAGIC  = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  RST_HEADER_BYTES = 8'd54;
    localparam logic [15:0] RST_MAGIC_WORD   = 16'd9002;
    localparam logic        RST_CHECK_MAGIC  = 1'b1;

    // Bits in a hidden byte field
    localparam logic [4:0] BYTE_BITS = 5'd8;

endpackage
`default_nettype wire

>>> design/lsb_stego_stream_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_stego_stream_extractor
// Recovers a hidden frame from the low bits of a stego image byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one file byte
//   per transfer; start_of_file restarts parsing on the first byte of a file.
//   Output channel (o_out_valid / i_out_ready / o_out_item) carries one
//   decoded field per transfer: magic bytes, lengths, extension and payload
//   bytes, or one error result that stops parsing until the next file.
//   Header and partial-field bytes produce no output transfer.
//   Throughput: one byte per cycle while the receiver keeps taking results.
//   A byte is held in the input register, then its result is captured in the
//   result register once that register is free or being taken.
//   When the receiver stalls, the result register holds its item and the
//   input register fills; o_in_ready drops while the input register holds a
//   byte behind a waiting result, and rises in the cycle the receiver takes
//   the result.
//   Reset clears both registers and the parse state (header skip) and loads
//   header_bytes 54, magic_word 9002, check_magic 1.
//   Configuration writes (i_cfg_wr_en, i_cfg_addr, i_cfg_wr_data) take effect
//   on the next edge; write only while the block is idle.
// ----------------------------------------------------------------------------
module lsb_stego_stream_extractor import lsep_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wr_data
);

    t_cfg      r_cfg;
    logic      w_held_valid;
    t_in_item  w_held_item;
    logic      w_step;
    logic      w_res_valid;
    t_out_item w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_bytes <= RST_HEADER_BYTES;
            r_cfg.magic_word   <= RST_MAGIC_WORD;
            r_cfg.check_magic  <= RST_CHECK_MAGIC;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_HEADER_BYTES: r_cfg.header_bytes <= i_cfg_wr_data[7:0];
                CFG_MAGIC_WORD:   r_cfg.magic_word   <= i_cfg_wr_data;
                CFG_CHECK_MAGIC:  r_cfg.check_magic  <= i_cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // Step the parser when a byte is held and the result register is free
    assign w_step = w_held_valid && (!o_out_valid || i_out_ready);

    lsep_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_take     (w_step),
        .o_valid    (w_held_valid),
        .o_item     (w_held_item)
    );

    lsep_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_step      (w_step),
        .i_item      (w_held_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    lsep_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_step),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

>>> design/lsep_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsep_in_reg
// Input register: holds one accepted file byte until the parser takes it.
// ----------------------------------------------------------------------------
module lsep_in_reg import lsep_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    input  wire logic     i_take,
    output logic          o_valid,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Accept when empty or when the held item leaves this cycle
    assign o_in_ready = !r_valid || i_take;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload on transfer
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

>>> design/lsep_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsep_parser
// Frame parser: gathers hidden bits and decodes magic, lengths and bytes.
// ----------------------------------------------------------------------------
module lsep_parser import lsep_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    output logic          o_res_valid,
    output t_out_item     o_res
);

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_hdr_cnt, n_hdr_cnt;
    logic [4:0]  r_bit_cnt, n_bit_cnt;
    logic [31:0] r_shift,  n_shift;
    logic        r_magic_idx, n_magic_idx;
    logic [31:0] r_remain, n_remain;

    logic [31:0] w_shift;
    logic [4:0]  w_bit_cnt;
    logic        w_is_len;
    logic        w_done;
    logic [31:0] w_val;
    logic [7:0]  w_expect;
    logic [31:0] w_remain_dec;

    // Next parse state and result for the byte in the input register
    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_magic_idx = r_magic_idx;
        n_remain    = r_remain;
        o_res_valid = 1'b0;
        o_res       = '0;
        w_shift     = '0;
        w_bit_cnt   = '0;
        w_is_len    = 1'b0;
        w_done      = 1'b0;
        w_val       = '0;
        w_expect    = '0;
        w_remain_dec = '0;

        // Restart on a new file
        if (i_item.start_of_file) begin
            n_phase     = PH_HEADER;
            n_hdr_cnt   = '0;
            n_bit_cnt   = '0;
            n_shift     = '0;
            n_magic_idx = 1'b0;
            n_remain    = '0;
        end

        // Drop header bytes, then open the magic field
        if (n_phase == PH_HEADER) begin
            if (n_hdr_cnt < i_cfg.header_bytes) begin
                n_hdr_cnt = n_hdr_cnt + 8'd1;
            end else begin
                n_phase     = PH_MAGIC;
                n_bit_cnt   = '0;
                n_shift     = '0;
                n_magic_idx = 1'b0;
            end
        end

        if (n_phase != PH_HEADER && n_phase != PH_STOP) begin
            w_shift   = {n_shift[30:0], i_item.image_byte[0]};
            w_bit_cnt = n_bit_cnt + 5'd1;
            w_is_len  = (n_phase == PH_EXT_LEN) || (n_phase == PH_PAY_LEN);
            // A length field ends when the 5-bit count wraps after 32 bits
            w_done    = w_is_len ? (w_bit_cnt == '0) : (w_bit_cnt == BYTE_BITS);
            w_val     = w_is_len ? w_shift : {24'd0, w_shift[7:0]};
            w_expect  = n_magic_idx ? i_cfg.magic_word[7:0] : i_cfg.magic_word[15:8];
            w_remain_dec = n_remain - 32'd1;

            if (!w_done) begin
                n_shift   = w_shift;
                n_bit_cnt = w_bit_cnt;
            end else begin
                n_shift     = '0;
                n_bit_cnt   = '0;
                o_res_valid = 1'b1;
                o_res.field_value = w_val;
                case (n_phase)
                    PH_MAGIC: begin
                        if (i_cfg.check_magic && (w_val[7:0] != w_expect)) begin
                            n_phase           = PH_STOP;
                            o_res.section     = SEC_ERROR;
                            o_res.field_value = '0;
                            o_res.error_code  = ERR_MAGIC;
                        end else begin
                            // Second magic byte moves on to the extension length
                            if (n_magic_idx) begin
                                n_phase = PH_EXT_LEN;
                            end
                            o_res.section = SEC_MAGIC;
                        end
                        n_magic_idx = 1'b1;
                    end
                    PH_EXT_LEN: begin
                        if (w_val == '0) begin
                            n_phase          = PH_STOP;
                            o_res.section    = SEC_ERROR;
                            o_res.error_code = ERR_EXT_ZERO;
                        end else begin
                            n_remain      = w_val;
                            n_phase       = PH_EXT_DATA;
                            o_res.section = SEC_EXT_LEN;
                        end
                    end
                    PH_EXT_DATA: begin
                        n_remain      = w_remain_dec;
                        if (w_remain_dec == '0) begin
                            n_phase = PH_PAY_LEN;
                        end
                        o_res.section = SEC_EXT_BYTE;
                    end
                    PH_PAY_LEN: begin
                        if (w_val == '0) begin
                            n_phase          = PH_STOP;
                            o_res.section    = SEC_ERROR;
                            o_res.error_code = ERR_PAY_ZERO;
                        end else begin
                            n_remain      = w_val;
                            n_phase       = PH_PAY_DATA;
                            o_res.section = SEC_PAY_LEN;
                        end
                    end
                    PH_PAY_DATA: begin
                        n_remain      = w_remain_dec;
                        if (w_remain_dec == '0) begin
                            n_phase            = PH_STOP;
                            o_res.last_payload = 1'b1;
                        end
                        o_res.section = SEC_PAY_BYTE;
                    end
                    default: begin
                        // Unused phase code: no result
                        o_res_valid = 1'b0;
                        o_res       = '0;
                        n_shift     = w_shift;
                        n_bit_cnt   = w_bit_cnt;
                    end
                endcase
            end
        end
    end

    // Advance parse state once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_magic_idx <= 1'b0;
            r_remain    <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_bit_cnt   <= n_bit_cnt;
            r_shift     <= n_shift;
            r_magic_idx <= n_magic_idx;
            r_remain    <= n_remain;
        end
    end

endmodule
`default_nettype wire

>>> design/lsep_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsep_out_reg
// Result register: holds one decoded field until the receiver takes it.
// ----------------------------------------------------------------------------
module lsep_out_reg import lsep_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire logic      i_res_valid,
    input  wire t_out_item i_res,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    logic      r_valid;
    t_out_item r_item;

    // Refill on a parser step, drop after a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload only when a result is produced
    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_item <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule
`default_nettype wire
